// ----- rtl/core/rrfe_pkg.sv -----
// Shared types and constants for the receive ring frame extractor.
// No dependencies; every module of the block imports this package.
package rrfe_pkg;

	// Field and register widths
	localparam int unsigned MAXLEN_W  = 13;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned BCNT_W    = 14;
	localparam int unsigned OUT_PTR_W = 16;
	localparam int unsigned PADDR_W   = 3;

	// Default read pointer width
	localparam int unsigned PTR_WIDTH_DEF = 16;

	// Reset value of max_frame_length
	localparam logic [MAXLEN_W-1:0] MAX_FRAME_RESET = 13'd2048;

	// CRC trailer length counted in the record length
	localparam logic [LEN_W-1:0] CRC_BYTES = 16'd4;

	// Offset taken off the read pointer when it is reported
	localparam logic [OUT_PTR_W-1:0] PTR_OFFSET = 16'h0010;

	// Status byte bits
	localparam int unsigned ST_OK_BIT    = 0;
	localparam int unsigned ST_ALIGN_BIT = 1;
	localparam int unsigned ST_CRC_BIT   = 2;

	// Register index of max_frame_length (paddr[2])
	localparam logic REG_MAX_FRAME = 1'b0;

	// Input item kind
	typedef enum logic {
		IK_RING_BYTE = 1'b0,
		IK_END_BATCH = 1'b1
	} in_kind_t;

	// Result kind
	typedef enum logic [1:0] {
		RK_PAYLOAD   = 2'd0,
		RK_POINTER   = 2'd1,
		RK_RESET_REQ = 2'd2
	} res_kind_t;

	// One input item
	typedef struct packed {
		in_kind_t    kind;
		logic [7:0]  ring_byte;
	} item_t;

	// One result item, with its valid flag
	typedef struct packed {
		logic                  valid;
		res_kind_t             kind;
		logic [7:0]            payload_byte;
		logic                  last_byte;
		logic [OUT_PTR_W-1:0]  pointer_value;
	} res_t;

endpackage

// ----- rtl/core/rx_ring_frame_extractor_core.sv -----
// Receive ring frame extractor: top level with the register port.
// Depends on rrfe_pkg, rrfe_in_stage, rrfe_parser, rrfe_out_stage.
//
// Use: ring bytes (s_tuser low) and end-of-batch marks (s_tuser high)
// enter on the slave stream. The master stream returns payload bytes
// with m_tlast on the last byte of a frame, read pointer updates
// (pointer minus 16) after each good record, and a receive-reset
// request on a bad header; m_tuser gives the result kind.
// An accepted request sits in the input register and is parsed there
// once the result register has room; its result, if any, is then loaded
// into the result register, which drives m_tvalid.
// Throughput: one request per cycle while the result register has room,
// set by the parser state update. Bytes that give no result pass through without a slot.
// Reset clears the parser to the header phase, the pointer to zero,
// both stream registers to empty and max_frame_length to 2048.
// When the receiver stalls, the result register holds its request,
// the parser waits and the input register fills; s_tready then drops.
// max_frame_length sits at byte address 0 on the APB port.
module rx_ring_frame_extractor_core
	import rrfe_pkg::*;
#(
	parameter int unsigned POINTER_WIDTH = PTR_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Slave stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] ring_byte
	input  logic               s_tuser,   // [0] kind
	// Master stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [7:0] payload_byte, [23:8] pointer_value
	output logic [1:0]         m_tuser,   // [1:0] result_kind
	output logic               m_tlast,
	// Register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [MAXLEN_W-1:0] max_len_q;
	item_t               in_item;
	item_t               item;
	logic                item_valid;
	logic                can_take;
	logic                fire;
	res_t                res;
	res_t                res_out;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_FRAME) ? 32'(max_len_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAME_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_MAX_FRAME) begin
			max_len_q <= pwdata[MAXLEN_W-1:0];
		end
	end

	// Input request
	assign in_item.kind      = in_kind_t'(s_tuser);
	assign in_item.ring_byte = s_tdata;
	assign fire              = item_valid && can_take;

	rrfe_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.fire       (fire),
		.item_valid (item_valid),
		.item       (item)
	);

	rrfe_parser #(
		.POINTER_WIDTH (POINTER_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item),
		.max_len (max_len_q),
		.res     (res)
	);

	rrfe_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res.valid),
		.res_in    (res),
		.can_take  (can_take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (res_out)
	);

	// Master payload
	assign m_tdata = {res_out.pointer_value, res_out.payload_byte};
	assign m_tuser = res_out.kind;
	assign m_tlast = res_out.last_byte;

	// A frame end is only ever flagged on a payload byte
	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == RK_PAYLOAD)
		else $error("tlast on a non-payload result");

	// Reported pointers sit on a 4-byte boundary
	a_ptr_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RK_POINTER |-> m_tdata[9:8] == 2'b00)
		else $error("pointer update not 4-byte aligned");

	// A held input request is not lost while the parser waits
	a_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !fire |=> item_valid && $stable(item))
		else $error("input request dropped while stalled");

endmodule

// ----- rtl/core/rrfe_in_stage.sv -----
// Input register of the frame extractor: holds one accepted request.
// Depends on rrfe_pkg.
module rrfe_in_stage
	import rrfe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  fire,
	output logic  item_valid,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	// Free, or emptying this cycle
	assign in_ready   = !valid_s1 || fire;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/core/rrfe_parser.sv -----
// Record parser of the frame extractor: header decode, payload, CRC and
// pad skip, read pointer and error recovery. Depends on rrfe_pkg.
module rrfe_parser
	import rrfe_pkg::*;
#(
	parameter int unsigned POINTER_WIDTH = PTR_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  item_t               item,
	input  logic [MAXLEN_W-1:0] max_len,
	output res_t                res
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_PAD,
		PH_DISCARD
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [1:0]               hcnt_q, hcnt_d;
	logic [7:0]               status_q, status_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [BCNT_W-1:0]        bcnt_q, bcnt_d;
	logic [POINTER_WIDTH-1:0] ptr_q, ptr_d;
	logic                     err_q, err_d;

	logic [POINTER_WIDTH-1:0] ptr_inc;
	logic [OUT_PTR_W-1:0]     ptr_report;
	logic                     aligned;
	logic [LEN_W-1:0]         hdr_len;
	logic                     hdr_bad;
	logic [LEN_W-1:0]         pos;
	logic [LEN_W-1:0]         pos_next;
	logic [LEN_W-1:0]         plen;

	// Pointer after consuming this byte, and its reported form
	assign ptr_inc    = ptr_q + 1'b1;
	assign ptr_report = OUT_PTR_W'(ptr_inc) - PTR_OFFSET;
	assign aligned    = (ptr_inc[1:0] == 2'b00);

	// Header check on the fourth header byte
	assign hdr_len = {item.ring_byte, len_q[7:0]};
	assign hdr_bad = !status_q[ST_OK_BIT] || status_q[ST_ALIGN_BIT] ||
		status_q[ST_CRC_BIT] || (hdr_len < CRC_BYTES) ||
		((hdr_len - CRC_BYTES) > LEN_W'(max_len));

	// Body position against payload length and record length
	assign pos      = LEN_W'(bcnt_q);
	assign pos_next = pos + 16'd1;
	assign plen     = len_q - CRC_BYTES;

	// Next state and result
	always_comb begin
		phase_d  = phase_q;
		hcnt_d   = hcnt_q;
		status_d = status_q;
		len_d    = len_q;
		bcnt_d   = bcnt_q;
		ptr_d    = ptr_q;
		err_d    = err_q;
		res      = '0;
		if (fire) begin
			if (item.kind == IK_END_BATCH) begin
				// End of batch only matters after an error
				if (phase_q == PH_DISCARD || err_q) begin
					ptr_d   = '0;
					err_d   = 1'b0;
					phase_d = PH_HEADER;
					hcnt_d  = 2'd0;
					bcnt_d  = '0;
				end
			end else begin
				case (phase_q)
					PH_HEADER: begin
						ptr_d = ptr_inc;
						case (hcnt_q)
							2'd0: begin
								status_d = item.ring_byte;
								hcnt_d   = hcnt_q + 2'd1;
							end
							2'd2: begin
								len_d[7:0] = item.ring_byte;
								hcnt_d     = hcnt_q + 2'd1;
							end
							2'd3: begin
								len_d  = hdr_len;
								hcnt_d = 2'd0;
								bcnt_d = '0;
								if (hdr_bad) begin
									err_d     = 1'b1;
									phase_d   = PH_DISCARD;
									res.valid = 1'b1;
									res.kind  = RK_RESET_REQ;
								end else begin
									phase_d = PH_BODY;
								end
							end
							default: begin
								hcnt_d = hcnt_q + 2'd1;
							end
						endcase
					end
					PH_BODY: begin
						ptr_d  = ptr_inc;
						bcnt_d = bcnt_q + 1'b1;
						if (pos < plen) begin
							res.valid        = 1'b1;
							res.kind         = RK_PAYLOAD;
							res.payload_byte = item.ring_byte;
							res.last_byte    = (pos_next == plen);
						end else if (pos_next == len_q) begin
							// CRC done: report now or skip pad first
							if (aligned) begin
								phase_d           = PH_HEADER;
								res.valid         = 1'b1;
								res.kind          = RK_POINTER;
								res.pointer_value = ptr_report;
							end else begin
								phase_d = PH_PAD;
							end
						end
					end
					PH_PAD: begin
						ptr_d = ptr_inc;
						if (aligned) begin
							phase_d           = PH_HEADER;
							res.valid         = 1'b1;
							res.kind          = RK_POINTER;
							res.pointer_value = ptr_report;
						end
					end
					default: begin
						// Discard: drop the byte
					end
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcnt_q   <= 2'd0;
			status_q <= 8'h00;
			len_q    <= '0;
			bcnt_q   <= '0;
			ptr_q    <= '0;
			err_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			hcnt_q   <= hcnt_d;
			status_q <= status_d;
			len_q    <= len_d;
			bcnt_q   <= bcnt_d;
			ptr_q    <= ptr_d;
			err_q    <= err_d;
		end
	end

endmodule

// ----- rtl/core/rrfe_out_stage.sv -----
// Result register of the frame extractor: holds one request for the
// downstream side. Depends on rrfe_pkg.
module rrfe_out_stage
	import rrfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	output logic can_take,
	output logic out_valid,
	input  logic out_ready,
	output res_t res_out
);

	logic out_valid_q;
	res_t res_q;

	// Room when empty or being drained this cycle
	assign can_take  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
